FILE: sv/tagged_slot_allocator_macros.svh
// assertion macros for the tagged slot allocator
// no dependencies; taken in by the modules that carry checks
`ifndef TAGGED_SLOT_ALLOCATOR_MACROS_SVH
`define TAGGED_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication, reset masks the check
`define TSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define TSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tsa_pkg.sv
// shared types, widths and codes of the tagged slot allocator
// used by tsa_dp, tsa_ctrl and tagged_slot_allocator; no dependencies
package tsa_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int ID_W      = 16;
  localparam int OP_W      = 2;
  localparam int SEAT_W    = 7;
  localparam int CNT_W     = 7;
  localparam int ST_W      = 3;
  localparam int CFG_W     = 7;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 40;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } tsa_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_SLOT     = 3'd1,
    ST_ALREADY_FREE = 3'd2,
    ST_NO_FREE      = 3'd3,
    ST_ID_EXISTS    = 3'd4
  } tsa_status_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_issue;
    logic seat_read;
    logic finish;
  } tsa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_reserve;
    logic is_clear;
    logic quick;
    logic seat_bad;
    logic scan_last;
    logic out_free;
  } tsa_sts_t;

  function automatic logic [CNT_W-1:0] sat_cap(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = CNT_W'(v);
    if (c < CNT_W'(2)) c = CNT_W'(2);
    else if (c > CNT_W'(NUM_SLOTS)) c = CNT_W'(NUM_SLOTS);
    return c;
  endfunction

endpackage

FILE: sv/tagged_slot_allocator.sv
// Tagged slot allocator: a table of up to 64 slots, each free or tagged with an owner id.
// Input requests (in_*): reserve the lowest free slot for an id, release or query a
// 1-based slot, or clear the table. Every request gives exactly one result (out_*)
// with a status, the granted slot, the owner and the free and used counts afterwards.
// cfg_we with cfg_wdata sets the capacity (held to 2..64) and empties the table;
// write it only while no request is in flight.
// A reserve that needs the table walk reads the owner memory one slot per cycle, up to
// the capacity, to find the lowest free slot and any duplicate id; release and query
// read one memory word; clear and requests settled without a read go straight to the
// result. One request is worked on at a time; the controller returns to idle as the
// result is registered and accepts the next request from there.
// Reset empties the table, sets capacity to 64 and drops any pending result.
// The result sits in an output register; while out_tready is low the next request
// is still accepted and worked on, and waits at its end for the register to empty.
// depends on tsa_pkg, tsa_ctrl and tsa_dp
module tagged_slot_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [tsa_pkg::CFG_W-1:0]  cfg_wdata,   // capacity
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [tsa_pkg::IN_W-1:0]   in_tdata,    // command, client_id, seat, zero pad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tsa_pkg::OUT_W-1:0]  out_tdata    // status, slot_granted, owner_id,
                                                  // free_count, used_count
);
  import tsa_pkg::*;

  tsa_cmd_t cmd;
  tsa_sts_t sts;

  tsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: sv/tsa_dp.sv
// datapath of the tagged slot allocator: owner memory, valid bits, counters, result register
// depends on tsa_pkg and tagged_slot_allocator_macros.svh
`include "tagged_slot_allocator_macros.svh"

module tsa_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [tsa_pkg::CFG_W-1:0] cfg_wdata,
  input  logic [tsa_pkg::IN_W-1:0] in_tdata,
  input  tsa_pkg::tsa_cmd_t        cmd,
  output tsa_pkg::tsa_sts_t        sts,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic [tsa_pkg::OUT_W-1:0] out_tdata
);
  import tsa_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  logic [ID_W-1:0]      mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0]     cap_r, cap_nxt, free_r, free_nxt, used_r, used_nxt;

  tsa_op_t              req_op_r;
  logic [ID_W-1:0]      req_id_r;
  logic [SEAT_W-1:0]    req_seat_r;

  logic [IDX_W-1:0]     idx_r, chk_idx_r, pick_r, rd_addr, seat_idx;
  logic                 chk_r, found_r, dup_r;
  logic [ID_W-1:0]      rd_data_r;
  logic                 rd_vld_r;
  logic                 seat_bad, wr_en;

  tsa_status_t          res_status;
  logic [CNT_W-1:0]     res_grant;
  logic [ID_W-1:0]      res_owner;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r;

  assign seat_idx = IDX_W'(req_seat_r - SEAT_W'(1));
  assign seat_bad = (req_seat_r == '0) || (CNT_W'(req_seat_r) > cap_r);
  assign rd_addr  = cmd.seat_read ? seat_idx : idx_r;

  assign sts.is_reserve = (req_op_r == OP_RESERVE);
  assign sts.is_clear   = (req_op_r == OP_CLEAR);
  assign sts.quick      = (free_r == '0) || (req_id_r == '0);
  assign sts.seat_bad   = seat_bad;
  assign sts.scan_last  = (idx_r == IDX_W'(cap_r - CNT_W'(1)));
  assign sts.out_free   = !out_valid_r || out_tready;

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op_r   <= tsa_op_t'(in_tdata[OP_W-1:0]);
      req_id_r   <= in_tdata[OP_W +: ID_W];
      req_seat_r <= in_tdata[OP_W+ID_W +: SEAT_W];
    end
    if (cmd.scan_start) begin
      idx_r   <= '0;
      found_r <= 1'b0;
      dup_r   <= 1'b0;
    end else begin
      if (cmd.scan_issue) idx_r <= idx_r + IDX_W'(1);
      if (chk_r) begin
        // lowest free slot wins, any live match with the id marks a duplicate
        if (!rd_vld_r && !found_r) begin
          found_r <= 1'b1;
          pick_r  <= chk_idx_r;
        end
        if (rd_vld_r && (rd_data_r == req_id_r)) dup_r <= 1'b1;
      end
    end
    chk_idx_r <= idx_r;
  end

  // owner memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[pick_r] <= req_id_r;
    if (cmd.scan_issue || cmd.seat_read) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_grant  = '0;
    res_owner  = '0;
    cap_nxt    = cap_r;
    free_nxt   = free_r;
    used_nxt   = used_r;
    vld_nxt    = vld_r;
    wr_en      = 1'b0;
    if (cfg_we) begin
      cap_nxt  = sat_cap(cfg_wdata);
      free_nxt = sat_cap(cfg_wdata);
      used_nxt = '0;
      vld_nxt  = '0;
    end else if (cmd.finish) begin
      case (req_op_r)
        OP_RESERVE: begin
          if (free_r == '0) begin
            res_status = ST_NO_FREE;
          end else if ((req_id_r == '0) || dup_r) begin
            res_status = ST_ID_EXISTS;
          end else begin
            wr_en           = 1'b1;
            vld_nxt[pick_r] = 1'b1;
            free_nxt        = free_r - CNT_W'(1);
            used_nxt        = used_r + CNT_W'(1);
            res_grant       = CNT_W'(pick_r) + CNT_W'(1);
          end
        end
        OP_RELEASE, OP_QUERY: begin
          if (seat_bad) begin
            res_status = ST_BAD_SLOT;
          end else if (req_op_r == OP_QUERY) begin
            res_owner = rd_vld_r ? rd_data_r : '0;
          end else if (!rd_vld_r) begin
            res_status = ST_ALREADY_FREE;
          end else begin
            res_owner         = rd_data_r;
            vld_nxt[seat_idx] = 1'b0;
            if (free_r < cap_r) free_nxt = free_r + CNT_W'(1);
            if (used_r != '0) used_nxt = used_r - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          vld_nxt  = '0;
          free_nxt = cap_r;
          used_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CNT_W'(NUM_SLOTS);
      free_r      <= CNT_W'(NUM_SLOTS);
      used_r      <= '0;
      vld_r       <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      free_r      <= free_nxt;
      used_r      <= used_nxt;
      vld_r       <= vld_nxt;
      chk_r       <= cmd.scan_issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data_r <= {used_nxt, free_nxt, res_owner, res_grant, res_status};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TSA_ASSERT_IMP(a_count_sum, clk, rst_n, 1'b1, (SUM_W'(free_r) + SUM_W'(used_r)) == SUM_W'(cap_r), "free plus used differs from capacity")
  `TSA_ASSERT_IMP(a_finish_room, clk, rst_n, cmd.finish, sts.out_free, "result written over a pending one")
  `TSA_ASSERT_IMP(a_grant_free, clk, rst_n, wr_en, found_r && !vld_r[pick_r], "grant of a slot that is taken")
  `TSA_ASSERT_NXT(a_cfg_clear, clk, rst_n, cfg_we, (vld_r == '0) && (used_r == '0) && (free_r == cap_r), "table not cleared after capacity write")

endmodule

FILE: sv/tsa_ctrl.sv
// sequencer of the tagged slot allocator: accepts a request and steps the datapath
// depends on tsa_pkg
module tsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tsa_pkg::tsa_sts_t sts,
  output tsa_pkg::tsa_cmd_t cmd
);
  import tsa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DISP = 6'b000010,
    S_SCAN = 6'b000100,
    S_TAIL = 6'b001000,
    S_READ = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_clear) begin
          state_nxt = S_DONE;
        end else if (sts.is_reserve) begin
          // full table or id zero: verdict needs no scan
          if (sts.quick) begin
            state_nxt = S_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (sts.seat_bad) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) state_nxt = S_TAIL;
      end
      S_TAIL: begin
        // last read word is compared here
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.seat_read = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: tb/tagged_slot_allocator_test.sv
// testbench for tagged_slot_allocator: directed and random requests checked against
// a cycle-free prediction of the owner table and its free and used counts
// depends on tsa_pkg and the tagged_slot_allocator rtl
`timescale 1ns / 100ps

module tagged_slot_allocator_test;
  import tsa_pkg::*;

  typedef struct {
    tsa_status_t       status;
    logic [SEAT_W-1:0] granted;
    logic [ID_W-1:0]   owner;
    logic [CNT_W-1:0]  free_cnt;
    logic [CNT_W-1:0]  used_cnt;
  } alloc_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;     // command, client_id, seat, zero pad
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;         // status, slot_granted, owner_id, free_count,
                                        // used_count

  // predicted table contents and counts
  logic [ID_W-1:0]   slot_owner [NUM_SLOTS];
  logic [CNT_W-1:0]  model_cap;
  logic [CNT_W-1:0]  model_free;
  logic [CNT_W-1:0]  model_used;

  alloc_result_t     pending_replies [$];
  int                mismatch_count = 0;
  bit                calm = 1'b0;      // no idling on either side while set

  tagged_slot_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [CNT_W-1:0] held_capacity(logic [CFG_W-1:0] v);
    int c;
    c = v;
    if (c < 2) c = 2;
    if (c > NUM_SLOTS) c = NUM_SLOTS;
    return CNT_W'(c);
  endfunction

  function automatic void empty_table();
    for (int i = 0; i < NUM_SLOTS; i++) slot_owner[i] = '0;
    model_free = model_cap;
    model_used = '0;
  endfunction

  function automatic alloc_result_t apply_request(tsa_op_t op, logic [ID_W-1:0] id,
                                                  logic [SEAT_W-1:0] seat);
    alloc_result_t r;
    int pick;
    int i;
    bit dup;
    r.status = ST_OK;
    r.granted = '0;
    r.owner = '0;
    case (op)
      OP_RESERVE: begin
        pick = -1;
        dup = 1'b0;
        i = 0;
        if (model_free != 0) begin
          while (i < model_cap && pick < 0) begin
            if (slot_owner[i] == '0) pick = i;
            i++;
          end
        end
        if (pick < 0) begin
          r.status = ST_NO_FREE;
        end else begin
          // id zero always matches the free slot just found
          for (i = 0; i < model_cap; i++) if (slot_owner[i] == id) dup = 1'b1;
          if (dup) begin
            r.status = ST_ID_EXISTS;
          end else begin
            slot_owner[pick] = id;
            model_free--;
            model_used++;
            r.granted = SEAT_W'(pick + 1);
          end
        end
      end
      OP_RELEASE, OP_QUERY: begin
        if (seat == 0 || seat > model_cap) begin
          r.status = ST_BAD_SLOT;
        end else if (op == OP_QUERY) begin
          r.owner = slot_owner[seat-1];
        end else if (slot_owner[seat-1] == '0) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          r.owner = slot_owner[seat-1];
          slot_owner[seat-1] = '0;
          if (model_free < model_cap) model_free++;
          if (model_used > 0) model_used--;
        end
      end
      default: empty_table();
    endcase
    r.free_cnt = model_free;
    r.used_cnt = model_used;
    return r;
  endfunction

  function automatic bit id_in_table(logic [ID_W-1:0] id);
    for (int i = 0; i < model_cap; i++) if (slot_owner[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom_range(1, 65535)); while (id_in_table(id));
    return id;
  endfunction

  // random occupied seat, 0 when the table is empty
  function automatic logic [SEAT_W-1:0] pick_used_seat();
    int k;
    if (model_used == 0) return '0;
    k = $urandom_range(0, model_used - 1);
    for (int i = 0; i < model_cap; i++) begin
      if (slot_owner[i] != '0) begin
        if (k == 0) return SEAT_W'(i + 1);
        k--;
      end
    end
    return '0;
  endfunction

  function automatic logic [ID_W-1:0] choose_id();
    int roll;
    logic [SEAT_W-1:0] s;
    roll = $urandom_range(0, 99);
    if (roll < 60) return fresh_id();
    if (roll < 78) begin
      s = pick_used_seat();
      return (s != 0) ? slot_owner[s-1] : ID_W'($urandom);
    end
    if (roll < 83) return '0;
    return ID_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [SEAT_W-1:0] choose_seat();
    int roll;
    logic [SEAT_W-1:0] s;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      s = pick_used_seat();
      return (s != 0) ? s : SEAT_W'($urandom_range(1, model_cap));
    end
    if (roll < 85) return SEAT_W'($urandom_range(1, model_cap));
    return SEAT_W'($urandom_range(0, 127));
  endfunction

  // valid stays high after a request so back-to-back requests need one assignment
  task automatic send_request(tsa_op_t op, logic [ID_W-1:0] id, logic [SEAT_W-1:0] seat);
    int gap;
    if (!calm && $urandom_range(0, 99) < 15) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 70) : $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W - SEAT_W - ID_W - OP_W){1'b0}}, seat, id, op};
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(apply_request(op, id, seat));
  endtask

  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_capacity(logic [CFG_W-1:0] v);
    wait_until_idle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_cap = held_capacity(v);
    empty_table();
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result %h with no request pending", out_tdata);
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[2:0] !== want.status || out_tdata[9:3] !== want.granted ||
            out_tdata[25:10] !== want.owner || out_tdata[32:26] !== want.free_cnt ||
            out_tdata[39:33] !== want.used_cnt) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: exp st=%0d slot=%0d owner=%h free=%0d used=%0d, got st=%0d slot=%0d owner=%h free=%0d used=%0d",
                     $realtime, want.status, want.granted, want.owner, want.free_cnt,
                     want.used_cnt, out_tdata[2:0], out_tdata[9:3], out_tdata[25:10],
                     out_tdata[32:26], out_tdata[39:33]);
        end
      end
    end
    out_tready <= calm || ($urandom_range(0, 99) >= 15);
  end

  // full capacity straight out of reset
  task automatic test_reset_state();
    send_request(OP_QUERY, 16'h0, 7'd64);
    send_request(OP_QUERY, 16'h0, 7'd65);
    send_request(OP_RESERVE, 16'h1234, 7'd0);
    send_request(OP_RELEASE, 16'h0, 7'd1);
  endtask

  // two slots: every status, both ends of each field, ignored fields set
  task automatic test_small_table();
    apply_capacity(7'd1);
    send_request(OP_RESERVE, 16'h0000, 7'd127);
    send_request(OP_RESERVE, 16'hffff, 7'h55);
    send_request(OP_RESERVE, 16'hffff, 7'd0);
    send_request(OP_RESERVE, 16'h0001, 7'd0);
    send_request(OP_RESERVE, 16'h0000, 7'd0);   // full wins over the zero id
    send_request(OP_RESERVE, 16'h0007, 7'd0);
    send_request(OP_QUERY, 16'hffff, 7'd0);
    send_request(OP_QUERY, 16'h0000, 7'd3);
    send_request(OP_QUERY, 16'h0000, 7'd127);
    send_request(OP_QUERY, 16'h0000, 7'd1);
    send_request(OP_RELEASE, 16'habcd, 7'd2);
    send_request(OP_RELEASE, 16'h0000, 7'd2);
    send_request(OP_RELEASE, 16'h0000, 7'd0);
    send_request(OP_RELEASE, 16'h0000, 7'd3);
    send_request(OP_QUERY, 16'h0000, 7'd2);
    send_request(OP_RESERVE, 16'haaaa, 7'd0);
    send_request(OP_CLEAR, 16'hffff, 7'd127);
    send_request(OP_QUERY, 16'h0000, 7'd1);
  endtask

  // fill all 64 slots, then free and refill holes
  task automatic test_full_table();
    apply_capacity(7'd127);
    repeat (NUM_SLOTS) send_request(OP_RESERVE, fresh_id(), SEAT_W'($urandom));
    send_request(OP_RESERVE, fresh_id(), 7'd0);
    send_request(OP_RESERVE, 16'h0000, 7'd0);
    send_request(OP_QUERY, 16'h0000, 7'd64);
    send_request(OP_RELEASE, 16'h0000, 7'd64);
    send_request(OP_RELEASE, 16'h0000, 7'd33);
    send_request(OP_RESERVE, fresh_id(), 7'd0);
    send_request(OP_RESERVE, fresh_id(), 7'd0);
    send_request(OP_RESERVE, fresh_id(), 7'd0);
    send_request(OP_QUERY, 16'h0000, 7'd65);
  endtask

  task automatic test_random_traffic(logic [CFG_W-1:0] cap_value, int count);
    int roll;
    apply_capacity(cap_value);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) send_request(OP_RESERVE, choose_id(), SEAT_W'($urandom));
      else if (roll < 72) send_request(OP_RELEASE, ID_W'($urandom), choose_seat());
      else if (roll < 97) send_request(OP_QUERY, ID_W'($urandom), choose_seat());
      else send_request(OP_CLEAR, ID_W'($urandom), SEAT_W'($urandom));
    end
  endtask

  initial begin
    model_cap = CNT_W'(NUM_SLOTS);
    empty_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_small_table();
    test_full_table();
    test_random_traffic(7'd2, 110);
    test_random_traffic(7'd0, 60);
    test_random_traffic(7'd5, 110);
    calm = 1'b1;
    test_random_traffic(7'd16, 110);
    calm = 1'b0;
    test_random_traffic(7'd64, 130);
    test_random_traffic(7'd100, 100);
    test_random_traffic(CFG_W'($urandom_range(3, 63)), 110);
    wait_until_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
